/* hdl/fvn_pkg.sv */
package fvn_pkg;

   // Item fields and octave count
   localparam int OCTAVES = 4;
   localparam int IN_W = 29;
   localparam int OUT_W = 18;
   localparam int FRAC_W = 16;

   // Internal widths
   localparam int XS_W = IN_W + OCTAVES - 1;
   localparam int LAT_W = XS_W - FRAC_W;
   localparam int HASH_W = 32;
   localparam int NOISE_W = 32;
   localparam int SUM_W = NOISE_W + OCTAVES + 2;
   localparam int OUT_SHIFT = OCTAVES - 1 + 14;
   localparam int OCT_IDX_W = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
   localparam int CORNERS = 4;

   // Pipeline: stage 0 input register, 1..7 octave lanes, 8 sum and output
   localparam int STAGES = 9;

   // Corner hash constants
   localparam logic [HASH_W-1:0] HASH_MUL_A = 32'd1619;
   localparam logic [HASH_W-1:0] HASH_MUL_B = 32'd31337;
   localparam int HASH_ROT = 13;
   localparam logic [HASH_W-1:0] HASH_MUL_C = 32'd15731;
   localparam logic [HASH_W-1:0] HASH_ADD_C = 32'd789221;
   localparam logic [HASH_W-1:0] HASH_ADD_D = 32'd1376312589;
   localparam logic [HASH_W-1:0] HASH_MASK = 32'h7fffffff;
   localparam logic signed [NOISE_W-1:0] VAL_ONE = 32'sd1073741824;

   // Smoothstep: 3*2^16
   localparam logic [17:0] SMOOTH_K = 18'd196608;

   // Output range
   localparam int NOISE_MIN = -122880;
   localparam int NOISE_MAX = 122880;

   // Per-stage load enables
   typedef struct packed {
      logic [STAGES-1:0] load;
   } ctl_type;

endpackage

/* hdl/fvn_octave.sv */
module fvn_octave (
   input  logic                                 clock,
   input  fvn_pkg::ctl_type                     ctl,
   input  logic [fvn_pkg::OCT_IDX_W-1:0]        shift,
   input  logic signed [fvn_pkg::IN_W-1:0]      x_coord,
   input  logic signed [fvn_pkg::IN_W-1:0]      z_coord,
   output logic signed [fvn_pkg::NOISE_W-1:0]   noise
);
   import fvn_pkg::*;

   // floor((p*(1-w) + q*w)) written as p + floor((q-p)*w)
   function automatic logic signed [NOISE_W-1:0] mix(
      input logic signed [NOISE_W-1:0] p,
      input logic signed [NOISE_W-1:0] q,
      input logic [FRAC_W-1:0] w
   );
      logic signed [NOISE_W:0] d;
      logic signed [NOISE_W+FRAC_W+1:0] m;
      d = (NOISE_W+1)'(q) - (NOISE_W+1)'(p);
      m = d * $signed({1'b0, w});
      return p + NOISE_W'(m >>> FRAC_W);
   endfunction

   // Stage 1 inputs: scale, floor, corner seeds
   logic signed [XS_W-1:0] xs, zs;
   logic signed [LAT_W-1:0] xl, zl;
   logic [HASH_W-1:0] xa, za;
   logic [HASH_W-1:0] seed[CORNERS];
   logic [HASH_W-1:0] n1_in[CORNERS];

   always_comb begin
      xs = XS_W'(x_coord) <<< shift;
      zs = XS_W'(z_coord) <<< shift;
      xl = xs[XS_W-1:FRAC_W];
      zl = zs[XS_W-1:FRAC_W];
      xa = HASH_W'(xl);
      za = HASH_W'(zl);
      for (int c = 0; c < CORNERS; c++) begin
         seed[c] = (xa + HASH_W'(c % 2)) * HASH_MUL_A
                 + (za + HASH_W'(c / 2)) * HASH_MUL_B;
         n1_in[c] = (seed[c] << HASH_ROT) ^ seed[c];
      end
   end

   logic [HASH_W-1:0] n1_ff[CORNERS];
   logic [FRAC_W-1:0] fx1_ff, fz1_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         n1_ff <= n1_in;
         fx1_ff <= xs[FRAC_W-1:0];
         fz1_ff <= zs[FRAC_W-1:0];
      end
   end

   // Stage 2: n*n, f*f
   logic [HASH_W-1:0] n2_ff[CORNERS], sq2_ff[CORNERS];
   logic [2*FRAC_W-1:0] ffx2_ff, ffz2_ff;
   logic [FRAC_W-1:0] fx2_ff, fz2_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         for (int c = 0; c < CORNERS; c++) begin
            n2_ff[c] <= n1_ff[c];
            sq2_ff[c] <= n1_ff[c] * n1_ff[c];
         end
         ffx2_ff <= fx1_ff * fx1_ff;
         ffz2_ff <= fz1_ff * fz1_ff;
         fx2_ff <= fx1_ff;
         fz2_ff <= fz1_ff;
      end
   end

   // Stage 3: n*n*MUL_C + ADD_C, smoothstep weights
   logic [2*FRAC_W+17:0] wx_prod, wz_prod;

   always_comb begin
      wx_prod = ffx2_ff * (SMOOTH_K - {1'b0, fx2_ff, 1'b0});
      wz_prod = ffz2_ff * (SMOOTH_K - {1'b0, fz2_ff, 1'b0});
   end

   logic [HASH_W-1:0] n3_ff[CORNERS], t3_ff[CORNERS];
   logic [FRAC_W-1:0] u3_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         for (int c = 0; c < CORNERS; c++) begin
            n3_ff[c] <= n2_ff[c];
            t3_ff[c] <= sq2_ff[c] * HASH_MUL_C + HASH_ADD_C;
         end
         u3_ff <= wx_prod[2*FRAC_W+FRAC_W-1:2*FRAC_W];
         v3_ff <= wz_prod[2*FRAC_W+FRAC_W-1:2*FRAC_W];
      end
   end

   // Stage 4: n * t
   logic [HASH_W-1:0] p4_ff[CORNERS];
   logic [FRAC_W-1:0] u4_ff, v4_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         for (int c = 0; c < CORNERS; c++) begin
            p4_ff[c] <= n3_ff[c] * t3_ff[c];
         end
         u4_ff <= u3_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 5: corner values 1 - h/2^30 in Q1.30
   logic signed [NOISE_W-1:0] val5_ff[CORNERS];
   logic [FRAC_W-1:0] u5_ff, v5_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         for (int c = 0; c < CORNERS; c++) begin
            val5_ff[c] <= VAL_ONE - $signed((p4_ff[c] + HASH_ADD_D) & HASH_MASK);
         end
         u5_ff <= u4_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stage 6: blend along x on both rows
   logic signed [NOISE_W-1:0] top6_ff, bot6_ff;
   logic [FRAC_W-1:0] v6_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         top6_ff <= mix(val5_ff[0], val5_ff[1], u5_ff);
         bot6_ff <= mix(val5_ff[2], val5_ff[3], u5_ff);
         v6_ff <= v5_ff;
      end
   end

   // Stage 7: blend along z
   logic signed [NOISE_W-1:0] noise7_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         noise7_ff <= mix(top6_ff, bot6_ff, v6_ff);
      end
   end

   assign noise = noise7_ff;

endmodule

/* hdl/fbm_value_noise_2d.sv */
// Fractal value noise, 2-D, four octaves, Q12.16 in, Q1.16 out.
// Throughput: one item per cycle unless the result side stalls.
// Every octave has its own lane of hash and blend units.
// Stalls are absorbed stage by stage: bubbles collapse, nothing is lost or repeated.
// Reset (synchronous, active high) clears the stage valid bits only.
module fbm_value_noise_2d (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [fvn_pkg::IN_W-1:0]     req_x_coord,
   input  logic signed [fvn_pkg::IN_W-1:0]     req_z_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fvn_pkg::OUT_W-1:0]    rsp_noise_value
);
   import fvn_pkg::*;

   // Stage valid bits and load enables
   logic [STAGES-1:0] valid_ff, valid_in, load;
   ctl_type ctl;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
      ctl.load = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 0: input item register
   logic signed [IN_W-1:0] x0_ff, z0_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         x0_ff <= req_x_coord;
         z0_ff <= req_z_coord;
      end
   end

   // Stages 1..7: one lane per octave
   logic signed [NOISE_W-1:0] noise[OCTAVES];

   for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
      fvn_octave u_oct (
         .clock   (clock),
         .ctl     (ctl),
         .shift   (OCT_IDX_W'(i)),
         .x_coord (x0_ff),
         .z_coord (z0_ff),
         .noise   (noise[i])
      );
   end

   // Stage 8: weighted sum, floor to Q1.16
   logic signed [SUM_W-1:0] total;
   logic signed [SUM_W-1:0] total_sh;
   logic signed [OUT_W-1:0] rsp_ff;

   always_comb begin
      total = '0;
      for (int i = 0; i < OCTAVES; i++) begin
         total = total + (SUM_W'(noise[i]) <<< (OCTAVES - 1 - i));
      end
      total_sh = total >>> OUT_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (load[STAGES-1]) begin
         rsp_ff <= total_sh[OUT_W-1:0];
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_noise_value = rsp_ff;

endmodule

/* hdl/fvn_checker.sv */
module fvn_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [fvn_pkg::OUT_W-1:0]    rsp_noise_value
);
   import fvn_pkg::*;

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise_value))
      else $error("result item changed while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An empty output stage means every stage can load
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output stage");

   // Summed noise stays in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_noise_value) >= NOISE_MIN) &&
                    (int'(rsp_noise_value) <= NOISE_MAX))
      else $error("noise value out of range");

endmodule

bind fbm_value_noise_2d fvn_checker u_fvn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_noise_value (rsp_noise_value)
);

/* tb/tb_fbm_value_noise_2d.sv */
`timescale 1ns / 1ps

module tb_fbm_value_noise_2d;
   import fvn_pkg::*;

   localparam int PIPE_DEPTH = 9;
   localparam int RANDOM_POINTS = 1450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_W-1:0] req_x_coord = '0;
   logic signed [IN_W-1:0] req_z_coord = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_noise_value;

   fbm_value_noise_2d u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_coord(req_x_coord), .req_z_coord(req_z_coord),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_noise_value(rsp_noise_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected noise per accepted point, oldest first
   class noise_scoreboard;
      logic signed [OUT_W-1:0] pending_noise[$];
      int errors;
      int points;
      int checked;

      function automatic logic [31:0] lattice_hash(logic [31:0] a, logic [31:0] b);
         logic [31:0] n;
         n = a * 32'd1619 + b * 32'd31337;
         n = (n << 13) ^ n;
         return (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
      endfunction

      function automatic longint corner_level(logic [31:0] a, logic [31:0] b);
         return longint'(1073741824) - longint'({32'd0, lattice_hash(a, b)});
      endfunction

      function automatic longint smooth(longint f);
         return (f * f * (196608 - 2 * f)) >>> 32;
      endfunction

      // floor division by 2^16
      function automatic longint lerp16(longint p, longint q, longint w);
         return (p * (65536 - w) + q * w) >>> 16;
      endfunction

      function automatic longint octave_value(longint x, longint z);
         longint fx, fz, u, v, top, bot;
         logic [31:0] xa, za;
         fx = x & 64'hFFFF;
         fz = z & 64'hFFFF;
         xa = 32'((x - fx) >>> 16);
         za = 32'((z - fz) >>> 16);
         u = smooth(fx);
         v = smooth(fz);
         top = lerp16(corner_level(xa, za), corner_level(xa + 32'd1, za), u);
         bot = lerp16(corner_level(xa, za + 32'd1), corner_level(xa + 32'd1, za + 32'd1), u);
         return lerp16(top, bot, v);
      endfunction

      function void note_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] z);
         longint sum;
         logic signed [OUT_W-1:0] level;
         sum = 0;
         for (int i = 0; i < OCTAVES; i++)
            sum += octave_value(longint'(x) <<< i, longint'(z) <<< i) <<< (OCTAVES - 1 - i);
         level = OUT_W'(sum >>> (OCTAVES - 1 + 14));
         pending_noise.insert(pending_noise.size(), level);
         points++;
      endfunction

      function void check_noise(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (pending_noise.size() == 0) begin
            $display("%0t: unexpected noise_value %0d", $time, got);
            errors++;
            return;
         end
         want = pending_noise.pop_front();
         checked++;
         if (got !== want) begin
            $display("%0t: noise_value expected %0d actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   noise_scoreboard sb = new();
   bit stim_done = 1'b0;
   bit hold_rsp = 1'b0;

   // often no gap, else mostly short gaps, sometimes long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] z);
      req_valid <= 1'b1;
      req_x_coord <= x;
      req_z_coord <= z;
      do @(posedge clock); while (!req_ready);
      sb.note_point(x, z);
   endtask

   task automatic idle_req(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic signed [IN_W-1:0] rand_coord(int mode);
      case (mode)
         0: return IN_W'($urandom);
         1: return IN_W'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return IN_W'({$urandom_range(0, 8191), 16'd0} + $urandom_range(0, 3));
         default: return IN_W'({$urandom_range(0, 8191), 16'hFFFF} - $urandom_range(0, 3));
      endcase
   endfunction

   // Result side: check accepted results; the next block drives random stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_noise(rsp_noise_value);
   end

   initial begin
      int g;
      g = 0;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) rsp_ready <= 1'b0;
         else if (g > 0) begin
            rsp_ready <= 1'b0;
            g--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) g = gap_len();
         end
         @(posedge clock);
      end
   end

   initial begin
      logic signed [IN_W-1:0] dir_x[$];
      logic signed [IN_W-1:0] dir_z[$];
      int burst;
      int g;
      dir_x = '{IN_W'(0), {1'b0, {(IN_W-1){1'b1}}}, {1'b1, {(IN_W-1){1'b0}}}, IN_W'(-1),
                IN_W'(32'h8000), IN_W'(32'hFFFF), IN_W'(32'h10000), IN_W'(-65536),
                IN_W'(-65537), IN_W'(1), {1'b0, {(IN_W-1){1'b1}}}, {1'b1, {(IN_W-1){1'b0}}}};
      dir_z = '{IN_W'(0), {1'b0, {(IN_W-1){1'b1}}}, {1'b1, {(IN_W-1){1'b0}}}, IN_W'(-1),
                IN_W'(32'h8000), IN_W'(32'hFFFF), IN_W'(-65536), IN_W'(32'h10000),
                IN_W'(1), IN_W'(-65537), {1'b1, {(IN_W-1){1'b0}}}, {1'b0, {(IN_W-1){1'b1}}}};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes, lattice edges, negative floor
      foreach (dir_x[i]) send_point(dir_x[i], dir_z[i]);
      // pipeline fill under a blocked result side, starting from empty
      req_valid <= 1'b0;
      while (sb.pending_noise.size() != 0) @(posedge clock);
      hold_rsp = 1'b1;
      for (int i = 0; i < PIPE_DEPTH; i++) send_point(rand_coord(0), rand_coord(0));
      req_valid <= 1'b0;
      repeat (4) @(posedge clock);
      hold_rsp = 1'b0;

      // Random points with gaps
      burst = 0;
      for (int i = 0; i < RANDOM_POINTS; i++) begin
         if (i == RANDOM_POINTS / 2) begin
            // drain everything before continuing
            req_valid <= 1'b0;
            while (sb.pending_noise.size() != 0) @(posedge clock);
         end
         if (burst > 0) burst--;
         else if ($urandom_range(0, 2) == 0) begin
            g = gap_len();
            if (g > 0) idle_req(g);
         end else if ($urandom_range(0, 15) == 0) burst = $urandom_range(20, 60);
         send_point(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Finish once drained
   initial begin
      wait (stim_done);
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH * 3) @(posedge clock);
      $display("Checked %0d noise results from %0d points (extremes, lattice edges, random).",
               sb.checked, sb.points);
      if (sb.errors == 0)
         $display("[fbm_value_noise_2d] OK");
      else
         $display("[fbm_value_noise_2d] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", sb.pending_noise.size());
      $display("[fbm_value_noise_2d] ERROR");
      $finish;
   end

endmodule

/* files.f */
hdl/fvn_pkg.sv
hdl/fvn_octave.sv
hdl/fbm_value_noise_2d.sv
hdl/fvn_checker.sv
tb/tb_fbm_value_noise_2d.sv
